@@ hw/rtl/depthwise_causal_fir_stream_top_defines.svh @@
// assertion macros for the depthwise fir block
`ifndef DEPTHWISE_CAUSAL_FIR_STREAM_TOP_DEFINES_SVH
`define DEPTHWISE_CAUSAL_FIR_STREAM_TOP_DEFINES_SVH

// implication checked on every clock, held off during reset
`define DCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcf check failed");

// next-cycle implication
`define DCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcf check failed");

`endif

@@ hw/rtl/dcfs_pkg.sv @@
`default_nettype none
package dcfs_pkg;
    localparam int CHANNELS      = 64;
    localparam int MAX_TAPS      = 8;
    localparam int MAX_SPACING   = 4;
    localparam int HISTORY_DEPTH = 32;

    localparam int CH_W   = 6;
    localparam int TAP_W  = 3;
    localparam int HIST_W = 5;
    localparam int ACC_W  = 40;

    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_WEIGHT  = 2'd1;
    localparam logic [1:0] MODE_BIAS    = 2'd2;
    localparam logic [1:0] MODE_HISTORY = 2'd3;

    localparam logic [1:0] REG_TAP_COUNT   = 2'd0;
    localparam logic [1:0] REG_TAP_SPACING = 2'd1;

    typedef logic signed [15:0] q15_t;
endpackage
`default_nettype wire

@@ hw/rtl/depthwise_causal_fir_stream_top.sv @@
`default_nettype none
// Per-channel dilated causal FIR (depthwise conv1d) over 64 interleaved streams. Items:
// mode 0 sample, 1 weight load, 2 bias load, 3 history write. A sample item gives one result
// (bias + sum of weight[k] times sample at delay (taps-1-k)*spacing, rounded half up and
// saturated, clipped flags saturation); load items give none. The taps of a sample go through one
// shared multiply-accumulate unit and the single read port of the history memory, one tap per
// cycle. After reset a clearing pass zeroes history, pointers and biases, one history entry a
// cycle; no item is accepted meanwhile but configuration writes are taken as ever. Registers at
// paddr 0 (tap_count) and 4 (tap_spacing).
module depthwise_causal_fir_stream_top
    import dcfs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [5:0]  channel,
    input  wire logic [4:0]  slot,
    input  wire logic signed [15:0] value,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [5:0]  out_channel,
    output      logic signed [15:0] out_value,
    output      logic        clipped
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;

    localparam int HA_W = CH_W + HIST_W;
    localparam int WA_W = CH_W + TAP_W;

    // configuration
    logic [3:0] tap_count_reg;
    logic [2:0] tap_spacing_reg;
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg   <= 4'd4;
            tap_spacing_reg <= 3'd1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_TAP_SPACING[0])
                tap_spacing_reg <= pwdata[2:0];
            else
                tap_count_reg <= pwdata[3:0];
        end
    end
    always_comb
    begin
        if (paddr[2] == REG_TAP_SPACING[0])
            prdata = {29'd0, tap_spacing_reg};
        else
            prdata = {28'd0, tap_count_reg};
    end

    // effective tap count and spacing
    logic [3:0] taps;
    logic [2:0] dil;
    always_comb
    begin
        taps = tap_count_reg;
        if (taps == 4'd0)
            taps = 4'd1;
        if (taps > 4'(MAX_TAPS))
            taps = 4'(MAX_TAPS);
        dil = tap_spacing_reg;
        if (dil == 3'd0)
            dil = 3'd1;
        if (dil > 3'(MAX_SPACING))
            dil = 3'(MAX_SPACING);
    end

    // memories
    q15_t hist_mem [CHANNELS*HISTORY_DEPTH];
    q15_t wgt_mem  [CHANNELS*MAX_TAPS];
    q15_t bias_mem [CHANNELS];
    logic [HIST_W-1:0] ptr_mem [CHANNELS];

    logic [2:0]  state_reg, state_next;
    logic [HA_W:0] clr_reg;
    logic [1:0]  mode_reg;
    logic [CH_W-1:0] ch_reg;
    logic [4:0]  slot_reg;
    q15_t        val_reg;
    logic [3:0]  k_reg;        // tap being issued
    logic        rd_v_reg;     // read data valid for mac this cycle
    logic        rd_new_reg;   // tap at delay zero
    logic        last_reg;
    logic [HIST_W-1:0] ptr_reg;
    q15_t        hist_q, wgt_q, bias_q;
    logic [HIST_W-1:0] ptr_q;
    logic signed [ACC_W-1:0] acc_reg;
    logic        phase_reg;    // first mac cycle latches pointer and bias

    // tap delay (taps-1-k)*dil, narrow
    logic [3:0] rem;
    logic [6:0] delay;
    assign rem   = taps - 4'd1 - k_reg;
    assign delay = 7'(rem * dil);

    logic issue;
    logic [HA_W-1:0] rd_addr;
    assign issue   = (state_reg == ST_MAC) && phase_reg && (k_reg < taps);
    assign rd_addr = {ch_reg, HIST_W'(ptr_reg - delay[HIST_W-1:0])};

    // pointer and bias are read for the transaction on the input port
    always_ff @(posedge clk)
    begin
        hist_q <= hist_mem[rd_addr];
        wgt_q  <= wgt_mem[{ch_reg, k_reg[TAP_W-1:0]}];
        bias_q <= bias_mem[channel];
        ptr_q  <= ptr_mem[channel];
    end

    // write port selection
    logic            h_we;
    logic [HA_W-1:0] h_wa;
    q15_t            h_wd;
    always_comb
    begin
        h_we = 1'b0;
        h_wa = clr_reg[HA_W-1:0];
        h_wd = 16'sd0;
        priority if (state_reg == ST_CLEAR)
            h_we = 1'b1;
        else if (state_reg == ST_ROUND)
        begin
            h_we = 1'b1;
            h_wa = {ch_reg, ptr_reg};
            h_wd = val_reg;
        end
        else if (state_reg == ST_MAC && mode_reg == MODE_HISTORY && phase_reg &&
                 slot_reg != 5'd0)
        begin
            h_we = 1'b1;
            h_wa = {ch_reg, HIST_W'(ptr_reg - slot_reg)};
            h_wd = val_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (h_we)
            hist_mem[h_wa] <= h_wd;
        if (state_reg == ST_CLEAR && clr_reg[HIST_W-1:0] == '0)
        begin
            ptr_mem[clr_reg[HA_W-1:HIST_W]]  <= '0;
            bias_mem[clr_reg[HA_W-1:HIST_W]] <= 16'sd0;
        end
        else if (state_reg == ST_ROUND)
            ptr_mem[ch_reg] <= ptr_reg + HIST_W'(1);
        else if (state_reg == ST_MAC && mode_reg == MODE_BIAS)
            bias_mem[ch_reg] <= val_reg;
        if (state_reg == ST_MAC && mode_reg == MODE_WEIGHT && slot_reg < 5'(MAX_TAPS))
            wgt_mem[{ch_reg, slot_reg[TAP_W-1:0]}] <= val_reg;
    end

    // rounding and saturation
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-16:0] q;
    logic sat_hi, sat_lo;
    assign rnd    = acc_reg + ACC_W'(16384);
    assign q      = rnd[ACC_W-1:15];
    assign sat_hi = q > 25'sd32767;
    assign sat_lo = q < -25'sd32768;

    logic signed [31:0] prod;
    q15_t sample_s;
    assign sample_s = rd_new_reg ? val_reg : hist_q;
    assign prod     = wgt_q * sample_s;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg[HA_W]) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_MAC;
            ST_MAC:
            begin
                if (mode_reg != MODE_SAMPLE)
                begin
                    if (mode_reg != MODE_HISTORY || phase_reg) state_next = ST_IDLE;
                end
                else if (last_reg) state_next = ST_ROUND;
            end
            ST_ROUND: state_next = ST_WAIT;
            ST_WAIT:  if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            k_reg      <= '0;
            rd_v_reg   <= 1'b0;
            last_reg   <= 1'b0;
            phase_reg  <= 1'b0;
            out_valid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            rd_v_reg <= issue;
            last_reg <= 1'b0;
            if (state_reg == ST_IDLE && in_valid)
            begin
                k_reg     <= '0;
                phase_reg <= 1'b0;
            end
            if (state_reg == ST_MAC)
            begin
                phase_reg <= 1'b1;
                if (issue)
                begin
                    k_reg    <= k_reg + 4'd1;
                    last_reg <= (k_reg == taps - 4'd1);
                end
            end
            if (state_reg == ST_ROUND)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            mode_reg <= mode;
            ch_reg   <= channel;
            slot_reg <= slot;
            val_reg  <= value;
        end
        if (state_reg == ST_MAC && !phase_reg)
        begin
            ptr_reg <= ptr_q;
        end
        rd_new_reg <= (delay == 7'd0);
        if (state_reg == ST_MAC && !phase_reg)
            acc_reg <= ACC_W'(bias_q) <<< 15;
        else if (rd_v_reg && phase_reg)
            acc_reg <= acc_reg + ACC_W'(prod);
        if (state_reg == ST_ROUND)
        begin
            out_channel <= ch_reg;
            clipped     <= sat_hi | sat_lo;
            out_value   <= sat_hi ? 16'sd32767 : (sat_lo ? -16'sd32768 : q[15:0]);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/dcfs_checker.sv @@
`default_nettype none
`include "depthwise_causal_fir_stream_top_defines.svh"
module dcfs_checker
    import dcfs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [5:0]  out_channel,
    input wire logic signed [15:0] out_value,
    input wire logic        clipped
);
    `DCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_channel))
    `DCF_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid, !in_ready)
    `DCF_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
    `DCF_ASSERT_IMPL(a_clip_rail, clk, rst_n, out_valid && clipped, out_value == 16'sh7fff || out_value == 16'sh8000)
endmodule

bind depthwise_causal_fir_stream_top dcfs_checker u_dcfs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .out_value(out_value), .clipped(clipped)
);
`default_nettype wire
